// ===== design/ckm_pkg.sv =====
// ----------------------------------------------------------------------------
// ckm_pkg
// Shared constants and types for the canonical k-mer minimiser stream.
// ----------------------------------------------------------------------------
package ckm_pkg;

  // Width of a packed k-mer and of every hash value.
  localparam int unsigned KMER_BITS    = 56;
  // Number of hashes held in the sliding window.
  localparam int unsigned WINDOW_DEPTH = 8;

  localparam int unsigned KMER_BASES = KMER_BITS / 2;
  localparam int unsigned SEEN_MAX   = KMER_BASES + WINDOW_DEPTH;
  localparam int unsigned CNT_W      = $clog2(SEEN_MAX + 1);

  localparam int unsigned BASE_W = 8;
  localparam int unsigned CODE_W = 2;
  localparam logic [CODE_W-1:0] COMP_XOR = 2'b10;

  // Hash pipeline depth: the seven hash steps are paired into four stages.
  localparam int unsigned HASH_STAGES = 4;

  // Minimum tree over the window plus the new hash, padded to a power of two.
  localparam int unsigned TREE_LEAVES = WINDOW_DEPTH + 1;
  localparam int unsigned TREE_LVLS   = $clog2(TREE_LEAVES);
  localparam int unsigned TREE_PAD    = 1 << TREE_LVLS;
  localparam int unsigned TREE_NODES  = TREE_PAD - 1;

  typedef logic [KMER_BITS-1:0] kmer_t;

  // What a request does once it reaches the window.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FILL,
    KIND_FULL
  } kind_t;

  // Side information that travels with each request down the pipeline.
  typedef struct packed {
    logic  clr;
    kind_t kind;
  } tag_t;

endpackage

// ===== design/ckm_front.sv =====
// ----------------------------------------------------------------------------
// ckm_front
// Base decoding, forward and reverse-complement k-mer registers, base counter
// and selection of the canonical k-mer.
// ----------------------------------------------------------------------------
module ckm_front import ckm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BASE_W-1:0] in_base_byte,
  input  logic              in_first_base,
  output logic              s_valid,
  output tag_t              s_tag,
  output kmer_t             s_canon,
  input  logic              s_en
);

  kmer_t            fwd_r, rev_r;
  logic [CNT_W-1:0] cnt_r;
  logic             s_valid_r;
  tag_t             s_tag_r;
  kmer_t            s_canon_r;

  logic [CODE_W-1:0] code, comp;
  kmer_t             fwd_base, rev_base, fwd_nxt, rev_nxt, canon_nxt;
  logic [CNT_W-1:0]  cnt_base, cnt_nxt;
  kind_t             kind_nxt;
  logic              accept;

  assign in_ready = !s_valid_r || s_en;
  assign accept   = in_valid && in_ready;

  // A first base starts from cleared k-mers and counter.
  always_comb begin
    code     = in_base_byte[2:1];
    comp     = code ^ COMP_XOR;
    fwd_base = in_first_base ? '0 : fwd_r;
    rev_base = in_first_base ? '0 : rev_r;
    cnt_base = in_first_base ? '0 : cnt_r;
    fwd_nxt  = {fwd_base[KMER_BITS-3:0], code};
    rev_nxt  = {comp, rev_base[KMER_BITS-1:2]};
    cnt_nxt  = (cnt_base < CNT_W'(SEEN_MAX)) ? cnt_base + 1'b1 : cnt_base;
    canon_nxt = (fwd_nxt < rev_nxt) ? fwd_nxt : rev_nxt;
  end

  // Classify the request by how many bases have been seen.
  always_comb begin
    priority if (cnt_nxt < CNT_W'(KMER_BASES)) begin
      kind_nxt = KIND_NONE;
    end else if (cnt_nxt == CNT_W'(SEEN_MAX)) begin
      kind_nxt = KIND_FULL;
    end else begin
      kind_nxt = KIND_FILL;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r     <= '0;
      rev_r     <= '0;
      cnt_r     <= '0;
      s_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fwd_r <= fwd_nxt;
        rev_r <= rev_nxt;
        cnt_r <= cnt_nxt;
      end
      if (in_ready) begin
        // Requests with no hash and no clear need not travel further.
        s_valid_r <= accept && ((kind_nxt != KIND_NONE) || in_first_base);
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (in_ready) begin
      s_tag_r.clr  <= in_first_base;
      s_tag_r.kind <= kind_nxt;
      s_canon_r    <= canon_nxt;
    end
  end

  assign s_valid = s_valid_r;
  assign s_tag   = s_tag_r;
  assign s_canon = s_canon_r;

`ifndef SYNTH
  // The counter never passes its saturation value.
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SEEN_MAX))
    else $error("base counter beyond saturation");

  // A full-window request in the stage register matches a saturated counter.
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid_r && s_tag_r.kind == KIND_FULL) |-> cnt_r == CNT_W'(SEEN_MAX))
    else $error("full-window request without saturated counter");
`endif

endmodule

// ===== design/ckm_hash.sv =====
// ----------------------------------------------------------------------------
// ckm_hash
// Four-stage pipeline of the masked shift-add integer hash.
// ----------------------------------------------------------------------------
module ckm_hash import ckm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  i_valid,
  input  tag_t  i_tag,
  input  kmer_t i_val,
  output logic  i_en,
  output logic  o_valid,
  output tag_t  o_tag,
  output kmer_t o_val,
  input  logic  o_en
);

  // One pipeline stage of the hash: an add and, where present, an xor-shift.
  function automatic kmer_t mix_step(input int unsigned k, input kmer_t v);
    kmer_t a;
    kmer_t r;
    unique case (k)
      0: begin
        a = ~v + (v << 21);
        r = a ^ (a >> 24);
      end
      1: begin
        a = v + (v << 3) + (v << 8);
        r = a ^ (a >> 14);
      end
      2: begin
        a = v + (v << 2) + (v << 4);
        r = a ^ (a >> 28);
      end
      default: begin
        a = v + (v << 31);
        r = a;
      end
    endcase
    return r;
  endfunction

  logic  v_r   [HASH_STAGES];
  tag_t  tag_r [HASH_STAGES];
  kmer_t val_r [HASH_STAGES];

  logic  en     [HASH_STAGES];
  logic  prv_v  [HASH_STAGES];
  tag_t  prv_t  [HASH_STAGES];
  kmer_t prv_d  [HASH_STAGES];

  // Stage enables, from the output back to the input.
  always_comb begin
    en[HASH_STAGES-1] = !v_r[HASH_STAGES-1] || o_en;
    for (int k = HASH_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  // Inputs of each stage.
  always_comb begin
    prv_v[0] = i_valid;
    prv_t[0] = i_tag;
    prv_d[0] = i_val;
    for (int k = 1; k < HASH_STAGES; k++) begin
      prv_v[k] = v_r[k-1];
      prv_t[k] = tag_r[k-1];
      prv_d[k] = val_r[k-1];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HASH_STAGES; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < HASH_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= prv_v[k];
        end
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    for (int k = 0; k < HASH_STAGES; k++) begin
      if (en[k]) begin
        tag_r[k] <= prv_t[k];
        val_r[k] <= mix_step(k, prv_d[k]);
      end
    end
  end

  assign i_en    = en[0];
  assign o_valid = v_r[HASH_STAGES-1];
  assign o_tag   = tag_r[HASH_STAGES-1];
  assign o_val   = val_r[HASH_STAGES-1];

endmodule

// ===== design/ckm_winmin.sv =====
// ----------------------------------------------------------------------------
// ckm_winmin
// Sliding window of recent hashes and a registered minimum tree over the
// window and the incoming hash.
// ----------------------------------------------------------------------------
module ckm_winmin import ckm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  i_valid,
  input  tag_t  i_tag,
  input  kmer_t i_val,
  output logic  i_en,
  output logic  o_valid,
  output tag_t  o_tag,
  output kmer_t o_min,
  input  logic  o_en
);

  // First node of a tree level in the flat node array; level 1 is the widest.
  function automatic int unsigned lvl_off(input int unsigned l);
    return TREE_PAD - (TREE_PAD >> (l - 1));
  endfunction

  kmer_t win_r  [WINDOW_DEPTH];
  kmer_t node_r [TREE_NODES];
  logic  tv_r   [TREE_LVLS];
  tag_t  tt_r   [TREE_LVLS];

  kmer_t leaf     [TREE_PAD];
  kmer_t node_nxt [TREE_NODES];
  logic  en       [TREE_LVLS];
  logic  shift_in;

  // Level enables, from the output back to the input.
  always_comb begin
    en[TREE_LVLS-1] = !tv_r[TREE_LVLS-1] || o_en;
    for (int l = TREE_LVLS - 2; l >= 0; l--) begin
      en[l] = !tv_r[l] || en[l+1];
    end
  end

  assign shift_in = i_valid && en[0] &&
                    ((i_tag.kind == KIND_FILL) || (i_tag.kind == KIND_FULL));

  // Leaves: the current window, the new hash, and all-ones padding.
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      leaf[i] = win_r[i];
    end
    leaf[WINDOW_DEPTH] = i_val;
    for (int i = WINDOW_DEPTH + 1; i < TREE_PAD; i++) begin
      leaf[i] = '1;
    end
  end

  // One compare per node; each level reads the registers of the level below.
  always_comb begin
    for (int j = 0; j < TREE_PAD / 2; j++) begin
      node_nxt[j] = (leaf[2*j+1] < leaf[2*j]) ? leaf[2*j+1] : leaf[2*j];
    end
    for (int l = 2; l <= TREE_LVLS; l++) begin
      for (int j = 0; j < (TREE_PAD >> l); j++) begin
        node_nxt[lvl_off(l)+j] =
          (node_r[lvl_off(l-1)+2*j+1] < node_r[lvl_off(l-1)+2*j]) ?
          node_r[lvl_off(l-1)+2*j+1] : node_r[lvl_off(l-1)+2*j];
      end
    end
  end

  // Level valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < TREE_LVLS; l++) begin
        tv_r[l] <= 1'b0;
      end
    end else begin
      if (en[0]) begin
        tv_r[0] <= i_valid;
      end
      for (int l = 1; l < TREE_LVLS; l++) begin
        if (en[l]) begin
          tv_r[l] <= tv_r[l-1];
        end
      end
    end
  end

  // Tags, tree nodes and the window shift register.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      tt_r[0] <= i_tag;
    end
    for (int l = 1; l < TREE_LVLS; l++) begin
      if (en[l]) begin
        tt_r[l] <= tt_r[l-1];
      end
    end
    for (int l = 1; l <= TREE_LVLS; l++) begin
      if (en[l-1]) begin
        for (int j = 0; j < (TREE_PAD >> l); j++) begin
          node_r[lvl_off(l)+j] <= node_nxt[lvl_off(l)+j];
        end
      end
    end
    if (shift_in) begin
      for (int p = 0; p + 1 < WINDOW_DEPTH; p++) begin
        win_r[p] <= win_r[p+1];
      end
      win_r[WINDOW_DEPTH-1] <= i_val;
    end
  end

  assign i_en    = en[0];
  assign o_valid = tv_r[TREE_LVLS-1];
  assign o_tag   = tt_r[TREE_LVLS-1];
  assign o_min   = node_r[TREE_NODES-1];

`ifndef SYNTH
  // A request that carries no hash only ever travels to clear the emit state.
  a_none_is_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (tv_r[0] && tt_r[0].kind == KIND_NONE) |-> tt_r[0].clr)
    else $error("request without hash or clear in minimum tree");
`endif

endmodule

// ===== design/canonical_kmer_minimizer_stream.sv =====
// ----------------------------------------------------------------------------
// canonical_kmer_minimizer_stream
// Canonical k-mer window minimiser over a stream of DNA base bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one base byte per request; bits
//   2:1 give the base code. in_first_base starts a new sequence and clears
//   the k-mers, base count and emit history before that base is taken in.
//   Output channel (out_valid/out_ready) carries one 56-bit minimiser hash,
//   produced only when the window minimum differs from the last one sent.
//   No result appears until 36 bases of a sequence have been taken in.
// Timing:
//   One request per cycle is accepted while the output side keeps up.
//   Once a request is accepted, its result passes through the k-mer
//   register, four hash stages, four levels of the minimum tree and the
//   output register, in that order.
// Stalls:
//   While a result waits in the output register the earlier stages keep
//   filling empty slots; in_ready drops only once every stage holds a request.
// Reset:
//   Synchronous active-low reset empties the pipeline and clears the k-mers,
//   the base count and the emit history; no result is pending after it.
// ----------------------------------------------------------------------------
module canonical_kmer_minimizer_stream import ckm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BASE_W-1:0]    in_base_byte,
  input  logic                 in_first_base,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KMER_BITS-1:0] out_minimizer
);

  logic  f_valid, f_en;
  tag_t  f_tag;
  kmer_t f_canon;

  logic  h_valid, h_en;
  tag_t  h_tag;
  kmer_t h_val;

  logic  m_valid, m_en;
  tag_t  m_tag;
  kmer_t m_min;

  logic  out_valid_r;
  kmer_t minimizer_r;
  kmer_t last_r;
  logic  any_r;

  logic  out_free, m_take, emit, eff_any;

  ckm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_base_byte  (in_base_byte),
    .in_first_base (in_first_base),
    .s_valid       (f_valid),
    .s_tag         (f_tag),
    .s_canon       (f_canon),
    .s_en          (f_en)
  );

  ckm_hash u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (f_valid),
    .i_tag   (f_tag),
    .i_val   (f_canon),
    .i_en    (f_en),
    .o_valid (h_valid),
    .o_tag   (h_tag),
    .o_val   (h_val),
    .o_en    (h_en)
  );

  ckm_winmin u_winmin (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (h_valid),
    .i_tag   (h_tag),
    .i_val   (h_val),
    .i_en    (h_en),
    .o_valid (m_valid),
    .o_tag   (m_tag),
    .o_min   (m_min),
    .o_en    (m_en)
  );

  // The last tree level moves on whenever the output register can be loaded.
  assign out_free = !out_valid_r || out_ready;
  assign m_en     = out_free;
  assign m_take   = m_valid && out_free;

  // Emit only a changed minimum; a clear forgets the previous one.
  assign eff_any = any_r && !m_tag.clr;
  assign emit    = m_take && (m_tag.kind == KIND_FULL) &&
                   !(eff_any && (last_r == m_min));

  // Output register and emit history.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      any_r       <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        any_r       <= 1'b1;
      end else begin
        if (out_ready) begin
          out_valid_r <= 1'b0;
        end
        if (m_take && m_tag.clr) begin
          any_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      minimizer_r <= m_min;
      last_r      <= m_min;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_minimizer = minimizer_r;

`ifndef SYNTH
  // A pending result always belongs to the current emit history.
  a_pending_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> any_r)
    else $error("result pending with empty emit history");

  // The pending result is the value that later minima are compared with.
  a_pending_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (minimizer_r == last_r))
    else $error("pending result differs from last emitted minimum");
`endif

endmodule

// ===== tb/canonical_kmer_minimizer_stream_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_kmer_minimizer_stream_test
// Self-checking testbench for the canonical k-mer minimiser stream.
// A queue of base requests feeds a clocked driver, and a clocked monitor
// compares every minimiser that leaves the block with the value computed by
// a software model kept inside this module. The model is advanced whenever a
// base request is accepted. Both channels stall at random.
// ----------------------------------------------------------------------------
module canonical_kmer_minimizer_stream_test import ckm_pkg::*; ();

  localparam int PIPE_LATENCY   = 9;
  localparam int SETTLE_CYCLES  = PIPE_LATENCY + 4;
  localparam int TAIL_CYCLES    = 2 * PIPE_LATENCY + 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TOTAL_BASES    = 1350;
  localparam int GAP_PERCENT    = 19;
  localparam int STEADY_FROM    = 600;
  localparam int STEADY_TO      = 1000;
  localparam int PRINT_LIMIT    = 40;

  // One base request as queued for the driver.
  typedef struct {
    logic [BASE_W-1:0] base_byte;
    logic              first_base;
    bit                hold;
  } base_req_t;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic [BASE_W-1:0]    in_base_byte  = '0;
  logic                 in_first_base = 1'b0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic [KMER_BITS-1:0] out_minimizer;

  base_req_t pending_bases[$];
  kmer_t     expected_minimizers[$];
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  int        idle_cycles    = 0;
  int        settle_cycles  = 0;

  // Model state of the minimiser.
  kmer_t     fwd_kmer  = '0;
  kmer_t     rev_kmer  = '0;
  int        seen_count = 0;
  kmer_t     hash_window[WINDOW_DEPTH];
  kmer_t     last_min  = '0;
  bit        sent_any  = 1'b0;

  canonical_kmer_minimizer_stream u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_base_byte  (in_base_byte),
    .in_first_base (in_first_base),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_minimizer (out_minimizer)
  );

  always #4 clk = ~clk;

  // Shift-add integer hash; all arithmetic wraps at the k-mer width.
  function automatic kmer_t scramble_kmer(kmer_t key);
    kmer_t v;
    v = key;
    v = ~v + (v << 21);
    v = v ^ (v >> 24);
    v = v + (v << 3) + (v << 8);
    v = v ^ (v >> 14);
    v = v + (v << 2) + (v << 4);
    v = v ^ (v >> 28);
    v = v + (v << 31);
    return v;
  endfunction

  // Advances the model by one base and queues the minimiser it produces, if any.
  function automatic void take_base(logic [BASE_W-1:0] base_in, logic is_first);
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] comp;
    kmer_t             canon;
    kmer_t             fresh;
    kmer_t             lowest;
    int                slot;
    if (is_first) begin
      fwd_kmer   = '0;
      rev_kmer   = '0;
      seen_count = 0;
      last_min   = '0;
      sent_any   = 1'b0;
    end
    code = base_in[2:1];
    comp = code ^ COMP_XOR;
    fwd_kmer = {fwd_kmer[KMER_BITS-3:0], code};
    rev_kmer = {comp, rev_kmer[KMER_BITS-1:2]};
    if (seen_count < SEEN_MAX) seen_count++;
    if (seen_count < KMER_BASES) return;

    canon = (fwd_kmer < rev_kmer) ? fwd_kmer : rev_kmer;
    fresh = scramble_kmer(canon);
    slot  = seen_count - KMER_BASES;
    // The first hashes of a sequence only fill the window.
    if (slot < WINDOW_DEPTH) begin
      hash_window[slot] = fresh;
      return;
    end

    lowest = fresh;
    for (int p = 0; p < WINDOW_DEPTH; p++) begin
      if (hash_window[p] < lowest) lowest = hash_window[p];
    end
    for (int p = 0; p + 1 < WINDOW_DEPTH; p++) begin
      hash_window[p] = hash_window[p+1];
    end
    hash_window[WINDOW_DEPTH-1] = fresh;

    if (sent_any && last_min == lowest) return;
    sent_any = 1'b1;
    last_min = lowest;
    expected_minimizers = {expected_minimizers, lowest};
  endfunction

  // Picks a byte whose bits 2:1 carry the given code: usually a letter in
  // either case, sometimes an arbitrary byte with stray bits set.
  function automatic logic [BASE_W-1:0] spell_base(logic [CODE_W-1:0] code);
    logic [BASE_W-1:0] b;
    if ($urandom_range(99) < 25) begin
      b = BASE_W'($urandom);
    end else begin
      case (code)
        2'd0:    b = 8'h41;
        2'd1:    b = 8'h43;
        2'd2:    b = 8'h54;
        default: b = 8'h47;
      endcase
      if ($urandom_range(1)) b[5] = 1'b1;
    end
    b[2:1] = code;
    return b;
  endfunction

  task automatic queue_base(logic [BASE_W-1:0] b, logic is_first, bit hold);
    base_req_t req;
    req.base_byte  = b;
    req.first_base = is_first;
    req.hold       = hold;
    pending_bases = {pending_bases, req};
  endtask

  task automatic report_mismatch(string what);
    if (mismatch_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Driver: presents queued base requests and updates the model on acceptance.
  always @(posedge clk) begin : drive_bases
    bit steady;
    bit gap;
    bit hold_wait;
    base_req_t req;
    if (!rst_n) begin
      in_valid      <= 1'b0;
      settle_cycles <= 0;
    end else begin
      steady = (cycle_count >= STEADY_FROM) && (cycle_count < STEADY_TO);
      if (in_valid && in_ready) take_base(in_base_byte, in_first_base);

      if (expected_minimizers.size() == 0 && !in_valid) settle_cycles <= settle_cycles + 1;
      else settle_cycles <= 0;

      if (!in_valid || in_ready) begin
        gap       = !steady && ($urandom_range(99) < GAP_PERCENT);
        hold_wait = (pending_bases.size() != 0) && pending_bases[0].hold &&
                    (expected_minimizers.size() != 0 || settle_cycles < SETTLE_CYCLES);
        if (pending_bases.size() != 0 && !gap && !hold_wait) begin
          req = pending_bases.pop_front();
          in_valid      <= 1'b1;
          in_base_byte  <= req.base_byte;
          in_first_base <= req.first_base;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted minimiser against the oldest expectation.
  always @(posedge clk) begin : check_minimizers
    kmer_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_minimizers.size() == 0) begin
          report_mismatch($sformatf("unexpected minimizer %h", out_minimizer));
        end else begin
          want = expected_minimizers.pop_front();
          if (out_minimizer !== want)
            report_mismatch($sformatf("minimizer %h, expected %h", out_minimizer, want));
        end
      end
      out_ready <= ((cycle_count >= STEADY_FROM) && (cycle_count < STEADY_TO)) ||
                   ($urandom_range(99) >= GAP_PERCENT);
    end
  end

  // Watchdog on cycles in which neither channel moves a request.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int                seq_len;
    int                style;
    int                period;
    int                run_left;
    int                seq_no;
    int                r;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] run_code;
    logic [CODE_W-1:0] motif [0:7];
    logic [CODE_W-1:0] half [0:13];
    logic              is_first;

    // Short sequence straight after reset, with stray bits in the bytes.
    queue_base(8'h41, 1'b0, 1'b0);
    queue_base(8'h00, 1'b0, 1'b0);
    queue_base(8'hFF, 1'b0, 1'b0);
    queue_base(8'h43, 1'b0, 1'b0);
    queue_base(8'h47, 1'b0, 1'b0);
    queue_base(8'h54, 1'b0, 1'b0);
    queue_base(8'h61, 1'b0, 1'b0);
    queue_base(8'h63, 1'b0, 1'b0);
    queue_base(8'h67, 1'b0, 1'b0);
    queue_base(8'h74, 1'b0, 1'b0);
    queue_base(8'hF9, 1'b0, 1'b0);
    queue_base(8'h06, 1'b0, 1'b0);
    queue_base(8'h80, 1'b0, 1'b0);
    queue_base(8'h7F, 1'b0, 1'b0);
    // A new sequence cuts the short one off; the sender waits for a quiet block.
    queue_base(8'h54, 1'b1, 1'b1);
    queue_base(8'hAA, 1'b0, 1'b0);
    queue_base(8'h55, 1'b0, 1'b0);
    queue_base(8'h02, 1'b0, 1'b0);
    queue_base(8'h04, 1'b0, 1'b0);

    // Random sequences: plain, long runs, tandem repeats and palindromes.
    seq_no = 0;
    while (pending_bases.size() < TOTAL_BASES) begin
      r = $urandom_range(99);
      if (r < 10) seq_len = $urandom_range(1, KMER_BASES + WINDOW_DEPTH - 1);
      else if (r < 16) seq_len = $urandom_range(280, 400);
      else seq_len = $urandom_range(KMER_BASES + WINDOW_DEPTH, 160);
      style    = $urandom_range(3);
      period   = $urandom_range(1, 6);
      run_left = 0;
      run_code = '0;
      for (int k = 0; k < 8; k++) motif[k] = CODE_W'($urandom);
      for (int i = 0; i < seq_len; i++) begin
        case (style)
          1: begin
            if (run_left == 0) begin
              run_code = CODE_W'($urandom);
              run_left = $urandom_range(1, 12);
            end
            run_left--;
            code = run_code;
          end
          2: code = motif[i % period];
          3: begin
            // The first k-mer equals its own reverse complement.
            if (i < KMER_BASES / 2) begin
              code    = CODE_W'($urandom);
              half[i] = code;
            end else if (i < KMER_BASES) begin
              code = half[KMER_BASES - 1 - i] ^ COMP_XOR;
            end else begin
              code = CODE_W'($urandom);
            end
          end
          default: code = CODE_W'($urandom);
        endcase
        if (i == 0) is_first = ($urandom_range(19) != 0);
        else is_first = ($urandom_range(59) == 0);
        queue_base(spell_base(code), is_first, (i == 0) && (seq_no % 6 == 2));
      end
      seq_no++;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bases.size() != 0 || in_valid) @(posedge clk);
    while (expected_minimizers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
